### hw/rtl/insertion_sorter_unit_assert.svh
// Assertion macros for the insertion sorter checker.
`ifndef INSERTION_SORTER_UNIT_ASSERT_SVH
`define INSERTION_SORTER_UNIT_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define ISU_ASSERT(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("isu assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ISU_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("isu assertion failed");

`endif

### hw/rtl/isu_pkg.sv
// Package: capacity, widths and item types of the insertion sorter.
package isu_pkg;

  localparam int DEPTH = 64;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    final_item;
  } isu_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] sorted_value;
    logic                    end_of_list;
    logic                    dropped;
  } isu_out_t;

  // controller -> datapath
  typedef struct packed {
    logic insert;
    logic shift;
  } isu_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;
  } isu_status_t;

endpackage

### hw/rtl/isu_ctrl.sv
// Controller: collect items until the final one, then drain the sorted list.
module isu_ctrl
  import isu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        final_item,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  isu_status_t status,
  output isu_cmd_t    cmd
);

  typedef enum logic {
    ST_FILL,
    ST_EMIT
  } state_t;

  state_t state;

  assign in_ready   = (state == ST_FILL);
  assign out_valid  = (state == ST_EMIT);
  assign cmd.insert = in_valid && in_ready;
  assign cmd.shift  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
    end else begin
      case (state)
        ST_FILL: begin
          if (cmd.insert && final_item) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (cmd.shift && status.last) begin
            state <= ST_FILL;
          end
        end
        default: begin
          state <= ST_FILL;
        end
      endcase
    end
  end

endmodule

### hw/rtl/isu_dp.sv
// Datapath: compare-and-shift register array, fill count and overflow flag.
module isu_dp
  import isu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  isu_in_t     in_data,
  input  isu_cmd_t    cmd,
  output isu_status_t status,
  output isu_out_t    out_data
);

  logic signed [VAL_W-1:0] store      [DEPTH];
  logic signed [VAL_W-1:0] store_next [DEPTH];
  logic signed [VAL_W-1:0] lower_val  [DEPTH];
  logic                    gt         [DEPTH];
  logic                    lower_gt   [DEPTH];
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic                    overflow;
  logic                    overflow_next;
  logic                    full;

  assign full        = (count == CNT_W'(DEPTH));
  assign status.last = (count == CNT_W'(1));

  // Every cell compares against the new value at once; the valid entries are
  // ascending, so the cells that hold larger values form a contiguous top run.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = (CNT_W'(i) < count) && (store[i] > in_data.value);
    end
    lower_gt[0]  = 1'b0;
    lower_val[0] = in_data.value;
    for (int i = 1; i < DEPTH; i++) begin
      lower_gt[i]  = gt[i-1];
      lower_val[i] = store[i-1];
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      store_next[i] = store[i];
    end
    if (cmd.shift) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        store_next[i] = store[i+1];
      end
    end else if (cmd.insert && !full) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (gt[i] || (CNT_W'(i) == count)) begin
          store_next[i] = lower_gt[i] ? lower_val[i] : in_data.value;
        end
      end
    end
  end

  always_comb begin
    count_next    = count;
    overflow_next = overflow;
    if (cmd.shift) begin
      count_next = count - CNT_W'(1);
      if (status.last) begin
        overflow_next = 1'b0;
      end
    end else if (cmd.insert) begin
      if (full) begin
        overflow_next = 1'b1;
      end else begin
        count_next = count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    store <= store_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      count    <= count_next;
      overflow <= overflow_next;
    end
  end

  assign out_data.sorted_value = store[0];
  assign out_data.end_of_list  = status.last;
  assign out_data.dropped      = overflow;

endmodule

### hw/rtl/insertion_sorter_unit.sv
// Stable insertion sorter of signed 32-bit values: top level.
//
// Input channel in_valid/in_ready/in_data carries one value per item and a
// final_item mark. Each accepted value is inserted into an ascending register
// list on acceptance, so items of a set are taken back to back, one per clock.
// At most DEPTH values are kept; later ones are discarded and flagged.
// The item with final_item set is inserted too; from the next cycle the list
// drains on out_valid/out_ready/out_data, head first, one result per cycle
// while the receiver takes them. end_of_list marks the last result and
// dropped is high on every result of a set that lost values.
// The draining shifts the whole array down one cell per accepted result, so
// in_ready is low while draining.
// A stalled receiver simply holds the head result; nothing is lost.
// Synchronous reset empties the list and clears the overflow flag.
module insertion_sorter_unit
  import isu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  isu_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output isu_out_t out_data
);

  isu_cmd_t    cmd;
  isu_status_t status;

  isu_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .final_item (in_data.final_item),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .cmd        (cmd)
  );

  isu_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

### hw/rtl/isu_checker.sv
// Port-level checker for the insertion sorter, bound to the top level.
`include "insertion_sorter_unit_assert.svh"

module isu_checker
  import isu_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_ready,
  input isu_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input isu_out_t out_data
);

  // filling and draining never overlap
  `ISU_ASSERT(a_no_overlap, !(in_ready && out_valid))
  `ISU_ASSERT_NEXT(a_final_drains, in_valid && in_ready && in_data.final_item, out_valid)
  `ISU_ASSERT_NEXT(a_end_frees, out_valid && out_ready && out_data.end_of_list, in_ready)
  `ISU_ASSERT_NEXT(a_more_results, out_valid && out_ready && !out_data.end_of_list, out_valid)
  `ISU_ASSERT_NEXT(a_drop_steady, out_valid && out_ready && !out_data.end_of_list,
                   $stable(out_data.dropped))

endmodule

bind insertion_sorter_unit isu_checker u_isu_checker (.*);
